>>> src/uv_sphere_tessellator_macros.svh
// Assertion macros shared by the UV sphere tessellator RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef UV_SPHERE_TESSELLATOR_MACROS_SVH
`define UV_SPHERE_TESSELLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ust_pkg.sv
// Shared types, constants and pipeline geometry for the UV sphere tessellator.
// No dependencies; every RTL module imports this package.
package ust_pkg;

    localparam int FRAC_BITS    = 15;
    localparam int MAX_SEGMENTS = 255;
    localparam int SEG_W        = 8;
    localparam int DVS_W        = SEG_W + 1;
    localparam int DIV_W        = 40;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = DIV_W / DIV_STEP;
    localparam int DIV_LANES    = 4;
    localparam int NUM_TERMS    = 6;
    localparam int SIN_STAGES   = 2 + 3 * NUM_TERMS;
    localparam int SIN_FIRST    = 1 + DIV_STAGES;
    localparam int SEL_STAGE    = SIN_FIRST + SIN_STAGES;
    localparam int MUL_STAGE    = SEL_STAGE + 1;
    localparam int NUM_STAGES   = MUL_STAGE + 1;
    localparam int SHIFT_XY     = 61 - FRAC_BITS;
    localparam int SHIFT_Z      = 31 - FRAC_BITS;

    localparam int LANE_V  = 0;
    localparam int LANE_U  = 1;
    localparam int LANE_TS = 2;
    localparam int LANE_TT = 3;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    localparam logic [7:0] TERM_DIV [NUM_TERMS] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156
    };
    localparam logic [31:0] TERM_RCP [NUM_TERMS] = '{
        32'((64'd1 << 32) / 64'd6),   32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)
    };

    localparam logic signed [16:0] NRM_HI = 17'((1 << FRAC_BITS) - 1);
    localparam logic signed [16:0] NRM_LO = 17'(-(1 << FRAC_BITS));

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK  = 2'd1;
    localparam logic [SEG_W-1:0] SECTOR_RESET = 8'd36;
    localparam logic [SEG_W-1:0] STACK_RESET  = 8'd18;

    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_CELL   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [SEG_W-1:0] stack_index;
        logic [SEG_W-1:0] sector_index;
    } t_req;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic [15:0]        tex_s;
        logic [15:0]        tex_t;
        logic [15:0]        tri_a;
        logic [15:0]        tri_b;
        logic [15:0]        tri_c;
        logic               is_last;
    } t_res;

    typedef struct packed {
        logic        kind;
        logic        upper;
        logic        lower;
        logic [15:0] base_a;
        logic [15:0] base_b;
        logic [15:0] tex_s;
        logic [15:0] tex_t;
        logic [1:0]  quad_u;
        logic [1:0]  quad_v;
    } t_meta;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic                  last_valid;
    } t_pipe_ctl;

endpackage

>>> src/ust_ctrl.sv
// Valid bits and stage enables of the tessellator pipeline.
// Depends on ust_pkg.
module ust_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_keep,
    input  logic               i_sink_ready,
    output ust_pkg::t_pipe_ctl o_ctl
);
    import ust_pkg::*;

    localparam logic [NUM_STAGES-1:0] ALL_ONES = {NUM_STAGES{1'b1}};

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] w_en;

    // A stage may load when the sink takes or some stage at or above it is empty.
    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            w_en[k] = i_sink_ready || (|(~r_v & NUM_STAGES'(ALL_ONES << k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid && i_keep;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ctl.en         = w_en;
    assign o_ctl.last_valid = r_v[NUM_STAGES-1];

endmodule

>>> src/ust_div.sv
// Pipelined restoring divider, four lanes, four quotient bits per stage.
// Depends on ust_pkg.
module ust_div (
    input  logic                                                 i_clk,
    input  logic [ust_pkg::DIV_STAGES-1:0]                       i_en,
    input  logic [ust_pkg::DIV_LANES-1:0][ust_pkg::DIV_W-1:0]    i_dvd,
    input  logic [ust_pkg::DIV_LANES-1:0][ust_pkg::DVS_W-1:0]    i_dvs,
    output logic [ust_pkg::DIV_LANES-1:0][ust_pkg::DIV_W-1:0]    o_quo
);
    import ust_pkg::*;

    logic [DIV_LANES-1:0][DVS_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_LANES-1:0][DIV_W-1:0] r_dq  [DIV_STAGES];
    logic [DIV_LANES-1:0][DVS_W-1:0] n_rem [DIV_STAGES];
    logic [DIV_LANES-1:0][DIV_W-1:0] n_dq  [DIV_STAGES];

    always_comb begin
        logic [DVS_W-1:0] rem;
        logic [DIV_W-1:0] dq;
        logic [DVS_W:0]   t;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                if (s == 0) begin
                    rem = '0;
                    dq  = i_dvd[l];
                end else begin
                    rem = r_rem[s-1][l];
                    dq  = r_dq[s-1][l];
                end
                for (int b = 0; b < DIV_STEP; b++) begin
                    t = {rem, dq[DIV_W-1]};
                    if (t >= {1'b0, i_dvs[l]}) begin
                        rem = DVS_W'(t - {1'b0, i_dvs[l]});
                        dq  = {dq[DIV_W-2:0], 1'b1};
                    end else begin
                        rem = t[DVS_W-1:0];
                        dq  = {dq[DIV_W-2:0], 1'b0};
                    end
                end
                n_rem[s][l] = rem;
                n_dq[s][l]  = dq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_dq[s]  <= n_dq[s];
            end
        end
    end

    assign o_quo = r_dq[DIV_STAGES-1];

endmodule

>>> src/ust_sine.sv
// One pipelined quadrant sine lane: Taylor series in Q30, three stages a term.
// Depends on ust_pkg.
module ust_sine (
    input  logic                           i_clk,
    input  logic [ust_pkg::SIN_STAGES-1:0] i_en,
    input  logic [30:0]                    i_arg,
    output logic signed [33:0]             o_acc
);
    import ust_pkg::*;

    typedef struct packed {
        logic [31:0]        val;
        logic [31:0]        aux;
        logic [31:0]        x2;
        logic signed [33:0] acc;
    } t_sl;

    logic [30:0] r_th;
    logic [61:0] w_prod0;
    logic [61:0] w_sq;
    t_sl         r_st [1:SIN_STAGES-1];
    t_sl         n_st [1:SIN_STAGES-1];

    assign w_prod0 = {31'b0, i_arg} * {31'b0, HALF_PI_Q30};
    assign w_sq    = {31'b0, r_th} * {31'b0, r_th};

    always_comb begin
        logic [63:0] prod_m;
        logic [63:0] prod_d;
        logic [33:0] rem;
        logic [31:0] term;
        int          base;
        n_st[1].val = {1'b0, r_th};
        n_st[1].aux = '0;
        n_st[1].x2  = w_sq[61:30];
        n_st[1].acc = $signed({3'b000, r_th});
        for (int k = 0; k < NUM_TERMS; k++) begin
            base = 2 + 3 * k;
            prod_m = {32'b0, r_st[base-1].val} * {32'b0, r_st[base-1].x2};
            n_st[base]     = r_st[base-1];
            n_st[base].val = prod_m[61:30];
            n_st[base].aux = '0;

            prod_d = {32'b0, r_st[base].val} * {32'b0, TERM_RCP[k]};
            n_st[base+1]     = r_st[base];
            n_st[base+1].aux = prod_d[63:32];

            // The reciprocal estimate is low by at most one.
            rem  = {2'b0, r_st[base+1].val}
                 - 34'({2'b0, r_st[base+1].aux} * {26'b0, TERM_DIV[k]});
            term = r_st[base+1].aux + ((rem >= {26'b0, TERM_DIV[k]}) ? 32'd1 : 32'd0);
            n_st[base+2]     = r_st[base+1];
            n_st[base+2].val = term;
            n_st[base+2].aux = '0;
            if ((k % 2) == 0) begin
                n_st[base+2].acc = r_st[base+1].acc - $signed({2'b00, term});
            end else begin
                n_st[base+2].acc = r_st[base+1].acc + $signed({2'b00, term});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_th <= w_prod0[60:30];
        end
        for (int s = 1; s < SIN_STAGES; s++) begin
            if (i_en[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_acc = r_st[SIN_STAGES-1].acc;

endmodule

>>> src/ust_out.sv
// Result register: rounds and saturates vertex fields, emits cell triangles one by one.
// Depends on ust_pkg.
module ust_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ust_pkg::t_meta        i_meta,
    input  logic signed [63:0]    i_px,
    input  logic signed [63:0]    i_py,
    input  logic signed [31:0]    i_pz,
    input  logic                  i_ready,
    output logic                  o_take,
    output logic                  o_valid,
    output ust_pkg::t_res         o_res
);
    import ust_pkg::*;

    logic r_valid;
    logic r_pend;
    t_res r_res;
    t_res r_second;
    t_res n_first;
    t_res n_second;

    function automatic logic signed [15:0] round_mag(input logic signed [63:0] v,
                                                     input int sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? 16'(-q) : 16'(q);
    endfunction

    function automatic logic signed [15:0] sat_nrm(input logic signed [15:0] p);
        logic signed [16:0] d;
        d = $signed({p, 1'b0});
        if (d > NRM_HI) begin
            return 16'(NRM_HI);
        end
        if (d < NRM_LO) begin
            return 16'(NRM_LO);
        end
        return 16'(d);
    endfunction

    always_comb begin
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        px = round_mag(i_px, SHIFT_XY);
        py = round_mag(i_py, SHIFT_XY);
        pz = round_mag(64'(i_pz), SHIFT_Z);

        n_second         = '0;
        n_second.tri_a   = 16'(i_meta.base_a + 16'd1);
        n_second.tri_b   = i_meta.base_b;
        n_second.tri_c   = 16'(i_meta.base_b + 16'd1);
        n_second.is_last = 1'b1;

        n_first = '0;
        if (i_meta.kind == REQ_VERTEX) begin
            n_first.pos_x   = px;
            n_first.pos_y   = py;
            n_first.pos_z   = pz;
            n_first.nrm_x   = sat_nrm(px);
            n_first.nrm_y   = sat_nrm(py);
            n_first.nrm_z   = sat_nrm(pz);
            n_first.tex_s   = i_meta.tex_s;
            n_first.tex_t   = i_meta.tex_t;
            n_first.is_last = 1'b1;
        end else if (i_meta.upper) begin
            n_first.tri_a   = i_meta.base_a;
            n_first.tri_b   = i_meta.base_b;
            n_first.tri_c   = 16'(i_meta.base_a + 16'd1);
            n_first.is_last = !i_meta.lower;
        end else begin
            n_first = n_second;
        end
    end

    assign o_take = !r_valid || (i_ready && !r_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
            r_pend  <= i_valid && (i_meta.kind == REQ_CELL) && i_meta.upper
                       && i_meta.lower;
        end else if (i_ready) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_res    <= n_first;
            r_second <= n_second;
        end else if (r_valid && i_ready && r_pend) begin
            r_res <= r_second;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> src/uv_sphere_tessellator.sv
// UV sphere tessellator top level: config registers, phase setup and pipeline.
// Throughput: one request per cycle while the output register can take; a cell with
// two triangles holds the output register and stalls the pipeline until both are
// taken, one triangle per cycle while i_res_ready is high.
// Reset clears all valid bits and sets sector_count to 36 and stack_count to 18.
// Depends on ust_pkg, ust_ctrl, ust_div, ust_sine, ust_out and the macro header.
`include "uv_sphere_tessellator_macros.svh"

module uv_sphere_tessellator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  ust_pkg::t_req                     i_req,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output ust_pkg::t_res                     o_res,
    input  logic                              i_cfg_we,
    input  logic [ust_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ust_pkg::SEG_W-1:0]         i_cfg_data
);
    import ust_pkg::*;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    logic [SEG_W-1:0] r_sector_count;
    logic [SEG_W-1:0] r_stack_count;
    logic [SEG_W-1:0] w_nsec;
    logic [SEG_W-1:0] w_nstk;
    logic             w_keep;
    logic             w_take;
    t_pipe_ctl        w_ctl;

    t_meta r_meta [NUM_STAGES];
    t_meta n_meta0;
    t_meta w_meta_sin;

    logic [DIV_LANES-1:0][DIV_W-1:0] r_dvd;
    logic [DIV_LANES-1:0][DIV_W-1:0] n_dvd;
    logic [DIV_LANES-1:0][DVS_W-1:0] w_dvs;
    logic [DIV_LANES-1:0][DIV_W-1:0] w_quo;

    logic [31:0]        w_ph_u;
    logic [31:0]        w_ph_v;
    logic [3:0][30:0]   w_arg;
    logic signed [33:0] w_acc [4];

    logic signed [31:0] r_su, r_cu, r_sv, r_cv;
    logic signed [31:0] n_su, n_cu, n_sv, n_cv;
    logic signed [63:0] r_px, r_py;
    logic signed [31:0] r_pz;

    function automatic logic [SEG_W-1:0] seg_clamp(input logic [SEG_W-1:0] v,
                                                   input logic [SEG_W-1:0] lo);
        if (v < lo) begin
            return lo;
        end
        if (int'(v) > MAX_SEGMENTS) begin
            return SEG_W'(MAX_SEGMENTS);
        end
        return v;
    endfunction

    function automatic logic signed [31:0] sin_clamp(input logic signed [33:0] a);
        if (a < 0) begin
            return '0;
        end
        if (a > $signed({3'b000, Q30_ONE})) begin
            return $signed({1'b0, Q30_ONE});
        end
        return 32'(a);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count <= SECTOR_RESET;
            r_stack_count  <= STACK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SECTOR: r_sector_count <= i_cfg_data;
                CFG_STACK:  r_stack_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_nsec = seg_clamp(r_sector_count, SEG_W'(3));
    assign w_nstk = seg_clamp(r_stack_count, SEG_W'(2));

    always_comb begin
        logic [16:0] a_full;
        if (i_req.req_type == REQ_VERTEX) begin
            w_keep = (i_req.stack_index <= w_nstk) && (i_req.sector_index <= w_nsec);
        end else begin
            w_keep = (i_req.stack_index < w_nstk) && (i_req.sector_index < w_nsec);
        end
        a_full = 17'({9'b0, i_req.stack_index} * {8'b0, {1'b0, w_nsec} + 9'd1})
               + 17'(i_req.sector_index);
        n_meta0        = '0;
        n_meta0.kind   = i_req.req_type;
        n_meta0.upper  = i_req.stack_index != '0;
        n_meta0.lower  = i_req.stack_index != SEG_W'(w_nstk - 1'b1);
        n_meta0.base_a = a_full[15:0];
        n_meta0.base_b = 16'(a_full[15:0] + {8'b0, w_nsec} + 16'd1);

        n_dvd[LANE_V]  = DIV_W'(i_req.sector_index) << 32;
        n_dvd[LANE_U]  = DIV_W'(i_req.stack_index) << 31;
        n_dvd[LANE_TS] = (DIV_W'(i_req.sector_index) << (FRAC_BITS + 1)) + DIV_W'(w_nsec);
        n_dvd[LANE_TT] = (DIV_W'(i_req.stack_index) << (FRAC_BITS + 1)) + DIV_W'(w_nstk);
    end

    assign w_dvs[LANE_V]  = {1'b0, w_nsec};
    assign w_dvs[LANE_U]  = {1'b0, w_nstk};
    assign w_dvs[LANE_TS] = {w_nsec, 1'b0};
    assign w_dvs[LANE_TT] = {w_nstk, 1'b0};

    ust_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req_valid),
        .i_keep       (w_keep),
        .i_sink_ready (w_take),
        .o_ctl        (w_ctl)
    );

    assign o_req_ready = w_ctl.en[0];

    ust_div u_div (
        .i_clk (i_clk),
        .i_en  (w_ctl.en[1 +: DIV_STAGES]),
        .i_dvd (r_dvd),
        .i_dvs (w_dvs),
        .o_quo (w_quo)
    );

    assign w_ph_v = w_quo[LANE_V][31:0];
    assign w_ph_u = 32'(32'h4000_0000 - w_quo[LANE_U][31:0]);
    assign w_arg[0] = {1'b0, w_ph_u[29:0]};
    assign w_arg[1] = 31'(Q30_ONE - {1'b0, w_ph_u[29:0]});
    assign w_arg[2] = {1'b0, w_ph_v[29:0]};
    assign w_arg[3] = 31'(Q30_ONE - {1'b0, w_ph_v[29:0]});

    always_comb begin
        w_meta_sin        = r_meta[SIN_FIRST-1];
        w_meta_sin.tex_s  = w_quo[LANE_TS][15:0];
        w_meta_sin.tex_t  = w_quo[LANE_TT][15:0];
        w_meta_sin.quad_u = w_ph_u[31:30];
        w_meta_sin.quad_v = w_ph_v[31:30];
    end

    for (genvar g = 0; g < 4; g++) begin : g_sine
        ust_sine u_sine (
            .i_clk (i_clk),
            .i_en  (w_ctl.en[SIN_FIRST +: SIN_STAGES]),
            .i_arg (w_arg[g]),
            .o_acc (w_acc[g])
        );
    end

    always_comb begin
        logic signed [31:0] s0u, c0u, s0v, c0v;
        s0u = sin_clamp(w_acc[0]);
        c0u = sin_clamp(w_acc[1]);
        s0v = sin_clamp(w_acc[2]);
        c0v = sin_clamp(w_acc[3]);
        case (r_meta[SEL_STAGE-1].quad_u)
            QUAD_I:   begin n_su = s0u;  n_cu = c0u;  end
            QUAD_II:  begin n_su = c0u;  n_cu = -s0u; end
            QUAD_III: begin n_su = -s0u; n_cu = -c0u; end
            default:  begin n_su = -c0u; n_cu = s0u;  end
        endcase
        case (r_meta[SEL_STAGE-1].quad_v)
            QUAD_I:   begin n_sv = s0v;  n_cv = c0v;  end
            QUAD_II:  begin n_sv = c0v;  n_cv = -s0v; end
            QUAD_III: begin n_sv = -s0v; n_cv = -c0v; end
            QUAD_IV:  begin n_sv = -c0v; n_cv = s0v;  end
            default:  begin n_sv = s0v;  n_cv = c0v;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_meta[0] <= n_meta0;
            r_dvd     <= n_dvd;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_ctl.en[k]) begin
                r_meta[k] <= (k == SIN_FIRST) ? w_meta_sin : r_meta[k-1];
            end
        end
        if (w_ctl.en[SEL_STAGE]) begin
            r_su <= n_su;
            r_cu <= n_cu;
            r_sv <= n_sv;
            r_cv <= n_cv;
        end
        if (w_ctl.en[MUL_STAGE]) begin
            r_px <= r_cu * r_cv;
            r_py <= r_cu * r_sv;
            r_pz <= r_su;
        end
    end

    ust_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ctl.last_valid),
        .i_meta  (r_meta[NUM_STAGES-1]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .i_ready (i_res_ready),
        .o_take  (w_take),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

    `UST_ASSERT_NEXT(a_second_tri, o_res_valid && i_res_ready && !o_res.is_last, o_res_valid && o_res.is_last, "first triangle not followed by the last one")
    `UST_ASSERT_NOW(a_tri_no_pos, o_res_valid && (o_res.tri_a != 16'd0), (o_res.pos_z == 16'sd0) && (o_res.tex_t == 16'd0), "triangle result carries vertex data")
    `UST_ASSERT_NOW(a_ready_chain, w_take, o_req_ready, "request stalled while the output can take")
    `UST_ASSERT_NOW(a_tex_range, o_res_valid, o_res.tex_s <= 16'd32768, "texture s above one")

endmodule

>>> tb/uv_sphere_tessellator_test.sv
// Self-checking testbench for the UV sphere tessellator: random and directed grid requests.
// Predicts vertex and triangle results in a scoreboard class; depends on ust_pkg and the RTL.
// Runs several sector and stack settings, including the clamped extremes.
`timescale 1ns / 100ps

module uv_sphere_tessellator_test;
    import ust_pkg::*;

    localparam int LIMIT = 600000;
    localparam int SETTLE = 50;

    class sphere_scoreboard;
        t_res expected_q[$];
        int unsigned nsec = 36;
        int unsigned nstk = 18;
        int errors = 0;
        int vertices = 0;
        int triangles = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] val);
            if (idx == CFG_SECTOR) begin
                nsec = val;
            end else if (idx == CFG_STACK) begin
                nstk = val;
            end
        endfunction

        function void add_expected(t_res e);
            expected_q.insert(expected_q.size(), e);
        endfunction

        function longint quad_sin(longint unsigned r);
            longint unsigned th, x2, term;
            longint acc;
            th = (r * longint'(HALF_PI_Q30)) >> 30;
            x2 = (th * th) >> 30;
            term = th;
            acc = th;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc -= term;
                end else begin
                    acc += term;
                end
            end
            if (acc < 0) acc = 0;
            if (acc > longint'(Q30_ONE)) acc = Q30_ONE;
            return acc;
        endfunction

        function void sin_cos(logic [31:0] ph, output longint sn, output longint cs);
            longint s0, c0;
            s0 = quad_sin(ph[29:0]);
            c0 = quad_sin(64'h4000_0000 - ph[29:0]);
            case (ph[31:30])
                2'd0: begin sn = s0; cs = c0; end
                2'd1: begin sn = c0; cs = -s0; end
                2'd2: begin sn = -s0; cs = -c0; end
                default: begin sn = -c0; cs = s0; end
            endcase
        endfunction

        function longint round_mag(longint v, int sh);
            longint unsigned mag;
            mag = v < 0 ? -v : v;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return v < 0 ? -longint'(mag) : longint'(mag);
        endfunction

        function logic [15:0] sat_nrm(longint v);
            if (v > (1 << FRAC_BITS) - 1) return (1 << FRAC_BITS) - 1;
            if (v < -(1 << FRAC_BITS)) return -(1 << FRAC_BITS);
            return v[15:0];
        endfunction

        function logic [15:0] tex(longint unsigned num, longint unsigned den);
            return 16'(((num << (FRAC_BITS + 1)) + den) / (den * 2));
        endfunction

        function bit in_grid(t_req r);
            int unsigned sc, kc;
            sc = nsec < 3 ? 3 : nsec;
            kc = nstk < 2 ? 2 : nstk;
            if (r.req_type == REQ_VERTEX) return r.stack_index <= kc && r.sector_index <= sc;
            return r.stack_index < kc && r.sector_index < sc;
        endfunction

        function void note_request(t_req r);
            int unsigned sc, kc, a, b;
            logic [31:0] ph_u, ph_v;
            longint su, cu, sv, cv, px, py, pz;
            t_res e;
            sc = nsec < 3 ? 3 : nsec;
            kc = nstk < 2 ? 2 : nstk;
            if (!in_grid(r)) return;
            e = '0;
            if (r.req_type == REQ_VERTEX) begin
                ph_v = 32'((longint'(r.sector_index) << 32) / sc);
                ph_u = 32'(64'h4000_0000 - ((longint'(r.stack_index) << 31) / kc));
                sin_cos(ph_u, su, cu);
                sin_cos(ph_v, sv, cv);
                px = round_mag(cu * cv, SHIFT_XY);
                py = round_mag(cu * sv, SHIFT_XY);
                pz = round_mag(su, SHIFT_Z);
                e.pos_x = px[15:0];
                e.pos_y = py[15:0];
                e.pos_z = pz[15:0];
                e.nrm_x = sat_nrm(2 * px);
                e.nrm_y = sat_nrm(2 * py);
                e.nrm_z = sat_nrm(2 * pz);
                e.tex_s = tex(r.sector_index, sc);
                e.tex_t = tex(r.stack_index, kc);
                e.is_last = 1'b1;
                add_expected(e);
            end else begin
                a = r.stack_index * (sc + 1) + r.sector_index;
                b = a + sc + 1;
                if (r.stack_index != 0) begin
                    e.tri_a = a[15:0];
                    e.tri_b = b[15:0];
                    e.tri_c = 16'(a + 1);
                    e.is_last = r.stack_index == kc - 1;
                    add_expected(e);
                end
                if (r.stack_index != kc - 1) begin
                    e.tri_a = 16'(a + 1);
                    e.tri_b = b[15:0];
                    e.tri_c = 16'(b + 1);
                    e.is_last = 1'b1;
                    add_expected(e);
                end
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task cmp(string nm, logic [15:0] got, logic [15:0] want);
            if (got !== want) report($sformatf("%s got %h expected %h", nm, got, want));
        endtask

        task check_result(t_res got);
            t_res w;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            w = expected_q.pop_front();
            if (w.tri_a == 0 && w.tri_b == 0) vertices++;
            else triangles++;
            cmp("pos_x", got.pos_x, w.pos_x);
            cmp("pos_y", got.pos_y, w.pos_y);
            cmp("pos_z", got.pos_z, w.pos_z);
            cmp("nrm_x", got.nrm_x, w.nrm_x);
            cmp("nrm_y", got.nrm_y, w.nrm_y);
            cmp("nrm_z", got.nrm_z, w.nrm_z);
            cmp("tex_s", got.tex_s, w.tex_s);
            cmp("tex_t", got.tex_t, w.tex_t);
            cmp("tri_a", got.tri_a, w.tri_a);
            cmp("tri_b", got.tri_b, w.tri_b);
            cmp("tri_c", got.tri_c, w.tri_c);
            cmp("is_last", 16'(got.is_last), 16'(w.is_last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_res_valid;
    logic i_res_ready = 1'b0;
    t_res o_res;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SEG_W-1:0] i_cfg_data = '0;

    sphere_scoreboard sb = new();
    bit quiet = 1'b0;
    int stall_left = 0;
    int cycles = 0;
    int phases = 0;

    uv_sphere_tessellator dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            stall_left = 0;
        end else if (o_res_valid && i_res_ready) begin
            sb.check_result(o_res);
            stall_left = quiet ? 0 : $urandom_range(0, 10);
            i_res_ready <= stall_left == 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_res_ready <= stall_left == 0;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    task send_request(logic kind, logic [7:0] si, logic [7:0] sj);
        int gap;
        t_req r;
        r.req_type = kind;
        r.stack_index = si;
        r.sector_index = sj;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
    endtask

    task drain;
        i_req_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task random_phase(int count);
        int done;
        int unsigned sc, kc;
        t_req r;
        done = 0;
        phases++;
        quiet = $urandom_range(0, 3) == 0;
        sc = sb.nsec < 3 ? 3 : sb.nsec;
        kc = sb.nstk < 2 ? 2 : sb.nstk;
        while (done < count) begin
            r.req_type = $urandom_range(0, 1);
            if ($urandom_range(0, 9) < 8) begin
                r.stack_index = $urandom_range(0, kc + 1 > 255 ? 255 : kc + 1);
                r.sector_index = $urandom_range(0, sc + 1 > 255 ? 255 : sc + 1);
            end else begin
                r.stack_index = $urandom_range(0, 255);
                r.sector_index = $urandom_range(0, 255);
            end
            done++;
            send_request(r.req_type, r.stack_index, r.sector_index);
            if ($urandom_range(0, 99) == 0) quiet = !quiet;
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_VERTEX, 0, 0);
        send_request(REQ_VERTEX, 18, 36);
        send_request(REQ_VERTEX, 9, 9);
        send_request(REQ_VERTEX, 19, 0);
        send_request(REQ_VERTEX, 0, 37);
        send_request(REQ_CELL, 0, 0);
        send_request(REQ_CELL, 17, 35);
        send_request(REQ_CELL, 5, 5);
        send_request(REQ_CELL, 18, 0);
        send_request(REQ_CELL, 0, 36);
        send_request(REQ_VERTEX, 255, 255);
        send_request(REQ_CELL, 255, 255);
        drain();
        write_reg(CFG_SECTOR, 8'd255);
        write_reg(CFG_STACK, 8'd255);
        send_request(REQ_VERTEX, 255, 255);
        send_request(REQ_VERTEX, 128, 64);
        send_request(REQ_CELL, 254, 254);
        send_request(REQ_CELL, 0, 254);
        send_request(REQ_CELL, 127, 200);
        drain();
        write_reg(2'd2, 8'hA5);
        write_reg(2'd3, 8'h5A);

        random_phase(150);
        write_reg(CFG_SECTOR, 8'd3);
        write_reg(CFG_STACK, 8'd2);
        random_phase(150);
        write_reg(CFG_SECTOR, 8'd0);
        write_reg(CFG_STACK, 8'd0);
        random_phase(100);
        write_reg(CFG_SECTOR, 8'd1);
        write_reg(CFG_STACK, 8'd1);
        random_phase(100);
        write_reg(CFG_SECTOR, 8'd7);
        write_reg(CFG_STACK, 8'd5);
        random_phase(150);
        write_reg(CFG_SECTOR, 8'd16);
        write_reg(CFG_STACK, 8'd200);
        random_phase(150);
        write_reg(CFG_SECTOR, 8'd200);
        write_reg(CFG_STACK, 8'd3);
        random_phase(150);
        write_reg(CFG_SECTOR, 8'd255);
        write_reg(CFG_STACK, 8'd255);
        random_phase(200);
        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_SECTOR, $urandom_range(0, 255));
            write_reg(CFG_STACK, $urandom_range(0, 255));
            random_phase(150);
        end

        $display("Checked %0d vertex and %0d triangle results over %0d register settings.",
                 sb.vertices, sb.triangles, phases + 2);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
